@@ rtl/lcr_pkg.sv @@
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared widths, register indexes and mode codes of the LED current regulator.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int SampleW  = 16;
  localparam int TargetW  = 10;
  localparam int DutyW    = 15;
  localparam int MeasW    = 16;
  localparam int ScaleW   = 24;
  localparam int GainW    = 16;
  localparam int IntegW   = 17;
  localparam int AccW     = 40;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int IncStep  = 10;

  localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PGAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IGAIN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DGAIN = 3'd5;

  localparam logic [1:0] MODE_BANG = 2'd0;
  localparam logic [1:0] MODE_INC  = 2'd1;
  localparam logic [1:0] MODE_PROP = 2'd2;
  localparam logic [1:0] MODE_PID  = 2'd3;

endpackage

@@ rtl/lcr_in_if.sv @@
// ----------------------------------------------------------------------------
// lcr_in_if
// Sample channel: converter sample and current setpoint with valid/ready.
// ----------------------------------------------------------------------------
interface lcr_in_if import lcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] adc_sample;
  logic [TargetW-1:0] set_current_ma;

  modport source (output valid, output adc_sample, output set_current_ma, input ready);
  modport sink   (input valid, input adc_sample, input set_current_ma, output ready);
endinterface

@@ rtl/lcr_out_if.sv @@
// ----------------------------------------------------------------------------
// lcr_out_if
// Result channel: new duty value and measured current with valid/ready.
// ----------------------------------------------------------------------------
interface lcr_out_if import lcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty_value;
  logic [MeasW-1:0] measured_ma;

  modport source (output valid, output duty_value, output measured_ma, input ready);
  modport sink   (input valid, input duty_value, input measured_ma, output ready);
endinterface

@@ rtl/led_current_regulator.sv @@
// ----------------------------------------------------------------------------
// led_current_regulator
// Current loop controller: scales a sample to milliamps and updates a PWM duty
// in bang-bang, incremental, proportional or PID mode, using one bit-serial
// shift-add multiplier for the scaling and for the three gain products.
// ----------------------------------------------------------------------------
//  channel   direction  payload                        handshake
//  in_i      sink       adc_sample, set_current_ma     valid/ready
//  out_o     source     duty_value, measured_ma        valid/ready
//  cfg       write      cfg_we_i, cfg_idx_i, cfg_wdata_i  write enable only
//
//  one multiplier bit per cycle, for the scaling and for each gain product
//  non-pid item: scaling, then the duty update; pid item: scaling, then the
//  P, I and D products; the next sample is taken once the result is stored
//  the result register holds one finished transaction while the next one runs
//  reset clears state and control and loads the default register values
// ----------------------------------------------------------------------------
module led_current_regulator import lcr_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcr_in_if.sink              in_i,
  lcr_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int CntW = 4;
  localparam logic [SampleW-1:0] SampleMask = SampleW'((32'd1 << SAMPLE_BITS) - 1);
  localparam logic [CntW-1:0]    MeasLast   = CntW'(SAMPLE_BITS - 1);
  localparam logic [CntW-1:0]    GainLast   = CntW'(GainW - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MEAS = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_PROP = 3'd3;
  localparam logic [2:0] ST_INTG = 3'd4;
  localparam logic [2:0] ST_DERV = 3'd5;
  localparam logic [2:0] ST_PIDF = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [1:0]         mode_q;
  logic [DutyW-1:0]   lim_q;
  logic [ScaleW-1:0]  scale_q;
  logic [GainW-1:0]   pgain_q, igain_q, dgain_q;

  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [GainW-1:0]   mplr_q, mplr_d;
  logic signed [AccW-1:0] mcand_q, mcand_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [TargetW-1:0] tgt_q, tgt_d;
  logic [MeasW-1:0]   meas_q, meas_d;
  logic [DutyW-1:0]   duty_q, duty_d;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic [MeasW-1:0]   last_q, last_d;
  logic               out_vld_q, out_vld_d;
  logic [DutyW-1:0]   out_duty_q, out_duty_d;
  logic [MeasW-1:0]   out_meas_q, out_meas_d;

  logic signed [AccW-1:0] acc_sum;
  logic [ScaleW-1:0]  scaled;
  logic [MeasW-1:0]   meas_w;
  logic signed [16:0] err_w;
  logic signed [17:0] lim_s, isum, integ_new, nxt;
  logic signed [16:0] dmeas;
  logic signed [AccW-1:0] pid_q;
  logic [DutyW-1:0]   pid_duty, nxt_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PID;
      lim_q   <= 15'd1000;
      scale_q <= 24'd65536;
      pgain_q <= 16'd5616;
      igain_q <= 16'd9484;
      dgain_q <= 16'd4150;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:  mode_q  <= cfg_wdata_i[1:0];
        REG_LIMIT: lim_q   <= cfg_wdata_i[DutyW-1:0];
        REG_SCALE: scale_q <= cfg_wdata_i[ScaleW-1:0];
        REG_PGAIN: pgain_q <= cfg_wdata_i[GainW-1:0];
        REG_IGAIN: igain_q <= cfg_wdata_i[GainW-1:0];
        REG_DGAIN: dgain_q <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign acc_sum = acc_q + (mplr_q[0] ? mcand_q : '0);
  assign scaled  = acc_q[AccW-1:16];
  assign meas_w  = (|scaled[ScaleW-1:MeasW]) ? {MeasW{1'b1}} : scaled[MeasW-1:0];
  assign err_w   = $signed({7'b0, tgt_q}) - $signed({1'b0, meas_w});
  assign lim_s   = $signed({3'b0, lim_q});
  assign isum    = {integ_q[IntegW-1], integ_q} + {err_w[16], err_w};
  assign dmeas   = $signed({1'b0, last_q}) - $signed({1'b0, meas_q});
  assign pid_q   = acc_q >>> GAIN_FRAC_BITS;

  always_comb begin
    if (isum > lim_s) begin
      integ_new = lim_s;
    end else if (isum < -lim_s) begin
      integ_new = -lim_s;
    end else begin
      integ_new = isum;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_BANG: nxt = (meas_w < {6'b0, tgt_q}) ? lim_s : 18'sd0;
      MODE_INC:  nxt = (meas_w < {6'b0, tgt_q}) ? $signed({3'b0, duty_q}) + 18'sd10
                                                : $signed({3'b0, duty_q}) - 18'sd10;
      default:   nxt = $signed({3'b0, duty_q}) + {err_w[16], err_w};
    endcase
    if (nxt < 18'sd0) begin
      nxt_duty = '0;
    end else if (nxt > lim_s) begin
      nxt_duty = lim_q;
    end else begin
      nxt_duty = nxt[DutyW-1:0];
    end
    if (acc_q < 0) begin
      pid_duty = '0;
    end else if (pid_q > $signed({{(AccW-DutyW){1'b0}}, lim_q})) begin
      pid_duty = lim_q;
    end else begin
      pid_duty = pid_q[DutyW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    mplr_d     = mplr_q;
    mcand_d    = mcand_q;
    acc_d      = acc_q;
    tgt_d      = tgt_q;
    meas_d     = meas_q;
    duty_d     = duty_q;
    integ_d    = integ_q;
    last_d     = last_q;
    out_duty_d = out_duty_q;
    out_meas_d = out_meas_q;
    out_vld_d  = out_vld_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mplr_d  = in_i.adc_sample & SampleMask;
          mcand_d = {{(AccW-ScaleW){1'b0}}, scale_q};
          acc_d   = '0;
          cnt_d   = MeasLast;
          tgt_d   = in_i.set_current_ma;
          state_d = ST_MEAS;
        end
      end
      ST_MEAS, ST_PROP, ST_INTG, ST_DERV: begin
        acc_d   = acc_sum;
        mplr_d  = mplr_q >> 1;
        mcand_d = mcand_q <<< 1;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d = GainLast;
          case (state_q)
            ST_MEAS: state_d = ST_CALC;
            ST_PROP: begin
              mplr_d  = igain_q;
              mcand_d = {{(AccW-IntegW){integ_q[IntegW-1]}}, integ_q};
              state_d = ST_INTG;
            end
            ST_INTG: begin
              mplr_d  = dgain_q;
              mcand_d = {{(AccW-17){dmeas[16]}}, dmeas};
              state_d = ST_DERV;
            end
            default: begin
              last_d  = meas_q;
              state_d = ST_PIDF;
            end
          endcase
        end
      end
      ST_CALC: begin
        meas_d = meas_w;
        if (mode_q == MODE_PID) begin
          integ_d = integ_new[IntegW-1:0];
          mplr_d  = pgain_q;
          mcand_d = {{(AccW-17){err_w[16]}}, err_w};
          acc_d   = '0;
          cnt_d   = GainLast;
          state_d = ST_PROP;
        end else begin
          duty_d  = nxt_duty;
          state_d = ST_EMIT;
        end
      end
      ST_PIDF: begin
        duty_d  = pid_duty;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_duty_d = duty_q;
          out_meas_d = meas_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      duty_q    <= '0;
      integ_q   <= '0;
      last_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      duty_q    <= duty_d;
      integ_q   <= integ_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplr_q     <= mplr_d;
    mcand_q    <= mcand_d;
    acc_q      <= acc_d;
    tgt_q      <= tgt_d;
    meas_q     <= meas_d;
    out_duty_q <= out_duty_d;
    out_meas_q <= out_meas_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.duty_value  = out_duty_q;
  assign out_o.measured_ma = out_meas_q;

endmodule
